FILE: design/wwtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wwtm_pkg
// Shared types, constants and helpers of the whole-word term matcher.
// ----------------------------------------------------------------------------
package wwtm_pkg;

	localparam int DEF_MAX_TERM    = 32;
	localparam int DEF_QUEUE_DEPTH = 2;

	localparam int TERM_BYTES  = 32;
	localparam int TERM_WORDS  = 4;
	localparam int TB_W        = 5;
	localparam int LEN_W       = 6;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int RES_MAX     = 2;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_PERIOD  = 8'h2e;
	localparam logic [7:0] CHAR_COMMA   = 8'h2c;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TERM_LENGTH = 3'd0,
		REG_TERM_WORD_0 = 3'd1,
		REG_TERM_WORD_1 = 3'd2,
		REG_TERM_WORD_2 = 3'd3,
		REG_TERM_WORD_3 = 3'd4,
		REG_IGNORE_CASE = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [LEN_W-1:0]                       term_length;
		logic [TERM_WORDS-1:0][CFG_DATA_W-1:0]  term_word;
		logic                                   ignore_case;
	} cfg_t;

	// classified text byte, front to back
	typedef struct packed {
		logic [7:0] text_byte;
		logic [7:0] cmp_byte;
		logic       is_space;
		logic       is_delim;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       flag_after;
		logic       last_of_segment;
	} res_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ic);
		logic [7:0] r;
		r = c;
		if (ic && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] tl,
		input int max_term);
		logic [LEN_W-1:0] r;
		r = tl;
		if (int'(tl) > max_term) begin
			r = LEN_W'(max_term);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/whole_word_term_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whole_word_term_matcher
// Streaming whole-word term finder with a one-byte lookahead.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle unless stalled and returns each byte one byte
// later, with flag_after set where a whole-word occurrence of the term ends.
// A byte's transaction leaves once the byte after it has been processed; the
// last byte of a segment comes out directly behind its predecessor, so that
// byte yields two transactions in a row. Sustained rate is one byte per cycle
// while result_ready is high, set by the combinational compare of the whole
// term window in the back end; a byte passes the front register, then the
// queue, before the back end takes it, and a two-entry result buffer absorbs
// the double transaction at a segment end. The user must write configuration
// only while no bytes are in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module whole_word_term_matcher #(
	parameter int MAX_TERM    = wwtm_pkg::DEF_MAX_TERM,
	parameter int QUEUE_DEPTH = wwtm_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [wwtm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [wwtm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                text_valid,
	output logic                                     text_ready,
	input  wire logic [7:0]                          text_byte,
	input  wire logic                                end_of_text,
	output logic                                     result_valid,
	input  wire logic                                result_ready,
	output logic [7:0]                               out_byte,
	output logic                                     flag_after,
	output logic                                     last_of_segment
);

	wwtm_pkg::cfg_t  cfg_q;
	logic            f_push_valid;
	wwtm_pkg::item_t f_push_item;
	logic            f_push_ready;
	logic            q_pop_valid;
	wwtm_pkg::item_t q_pop_item;
	logic            q_pop_ready;
	wwtm_pkg::res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.term_length <= wwtm_pkg::LEN_W'(1);
			cfg_q.term_word   <= '0;
			cfg_q.ignore_case <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wwtm_pkg::REG_TERM_LENGTH: cfg_q.term_length <= cfg_data[wwtm_pkg::LEN_W-1:0];
				wwtm_pkg::REG_TERM_WORD_0: cfg_q.term_word[0] <= cfg_data;
				wwtm_pkg::REG_TERM_WORD_1: cfg_q.term_word[1] <= cfg_data;
				wwtm_pkg::REG_TERM_WORD_2: cfg_q.term_word[2] <= cfg_data;
				wwtm_pkg::REG_TERM_WORD_3: cfg_q.term_word[3] <= cfg_data;
				wwtm_pkg::REG_IGNORE_CASE: cfg_q.ignore_case <= cfg_data[0];
				default:                   cfg_q <= cfg_q;
			endcase
		end
	end

	wwtm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.ignore_case (cfg_q.ignore_case),
		.push_valid  (f_push_valid),
		.push_item   (f_push_item),
		.push_ready  (f_push_ready)
	);

	wwtm_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_push_valid),
		.push_item  (f_push_item),
		.push_ready (f_push_ready),
		.pop_valid  (q_pop_valid),
		.pop_item   (q_pop_item),
		.pop_ready  (q_pop_ready)
	);

	wwtm_back #(
		.MAX_TERM (MAX_TERM)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_valid   (q_pop_valid),
		.item         (q_pop_item),
		.item_ready   (q_pop_ready),
		.result_valid (result_valid),
		.result       (res),
		.result_ready (result_ready)
	);

	assign out_byte        = res.out_byte;
	assign flag_after      = res.flag_after;
	assign last_of_segment = res.last_of_segment;

	// last term byte, for checking flagged transactions
	logic [wwtm_pkg::TERM_BYTES-1:0][7:0] chk_bytes;
	logic [wwtm_pkg::LEN_W-1:0]           chk_len;
	logic [wwtm_pkg::LEN_W-1:0]           chk_idx;
	logic [7:0]                           chk_byte;
	logic                                 chk_ok;

	assign chk_bytes = cfg_q.term_word;
	assign chk_len   = wwtm_pkg::eff_len(cfg_q.term_length, MAX_TERM);
	assign chk_idx   = chk_len - wwtm_pkg::LEN_W'(1);
	assign chk_byte  = (chk_idx < wwtm_pkg::LEN_W'(wwtm_pkg::TERM_BYTES)) ?
		chk_bytes[chk_idx[wwtm_pkg::TB_W-1:0]] : 8'h00;
	assign chk_ok    = (chk_len != '0) &&
		(wwtm_pkg::fold_byte(out_byte, cfg_q.ignore_case) ==
		 wwtm_pkg::fold_byte(chk_byte, cfg_q.ignore_case));

	a_flag_ends_term: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && flag_after |-> chk_ok)
		else $error("flagged byte is not the last term byte");

	a_zero_len_no_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (cfg_q.term_length == '0) |-> !flag_after)
		else $error("flag with zero term length");

	a_front_holds: assert property (@(posedge clk) disable iff (!arst_n)
		f_push_valid && !f_push_ready |=> f_push_valid && $stable(f_push_item))
		else $error("front dropped or changed a stalled transaction");

	a_eot_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop_valid && q_pop_ready && q_pop_item.end_of_text |=> result_valid)
		else $error("segment end produced no transaction");

endmodule
`default_nettype wire

FILE: design/wwtm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wwtm_front
// Accepts text bytes, folds case and marks delimiters into one register stage.
// ----------------------------------------------------------------------------
module wwtm_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            text_valid,
	output logic                 text_ready,
	input  wire logic [7:0]      text_byte,
	input  wire logic            end_of_text,
	input  wire logic            ignore_case,
	output logic                 push_valid,
	output wwtm_pkg::item_t      push_item,
	input  wire logic            push_ready
);

	logic            valid_s1;
	wwtm_pkg::item_t item_s1;
	logic            take;

	assign text_ready = !valid_s1 || push_ready;
	assign take       = text_valid && text_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.text_byte   <= text_byte;
			item_s1.cmp_byte    <= wwtm_pkg::fold_byte(text_byte, ignore_case);
			item_s1.is_space    <= (text_byte == wwtm_pkg::CHAR_SPACE);
			item_s1.is_delim    <= (text_byte == wwtm_pkg::CHAR_SPACE) ||
				(text_byte == wwtm_pkg::CHAR_PERIOD) || (text_byte == wwtm_pkg::CHAR_COMMA);
			item_s1.end_of_text <= end_of_text;
		end
	end

endmodule
`default_nettype wire

FILE: design/wwtm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wwtm_fifo
// Short queue of classified bytes between front and back (DEPTH >= 2).
// ----------------------------------------------------------------------------
module wwtm_fifo #(
	parameter int DEPTH = wwtm_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	input  wire wwtm_pkg::item_t push_item,
	output logic                 push_ready,
	output logic                 pop_valid,
	output wwtm_pkg::item_t      pop_item,
	input  wire logic            pop_ready
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	wwtm_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            push;
	logic            pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

FILE: design/wwtm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wwtm_back
// Byte history, parallel window compare, match bookkeeping and a two-entry
// result buffer.
// ----------------------------------------------------------------------------
module wwtm_back #(
	parameter int MAX_TERM = wwtm_pkg::DEF_MAX_TERM
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire wwtm_pkg::cfg_t  cfg,
	input  wire logic            item_valid,
	input  wire wwtm_pkg::item_t item,
	output logic                 item_ready,
	output logic                 result_valid,
	output wwtm_pkg::res_t       result,
	input  wire logic            result_ready
);

	localparam int LEN_W = wwtm_pkg::LEN_W;
	localparam int SAT   = MAX_TERM + 1;
	localparam int CW    = $clog2(MAX_TERM + 2);
	localparam int CMP_W = ((CW > LEN_W) ? CW : LEN_W) + 1;
	localparam int SPW   = $clog2(MAX_TERM + 1);

	// history: folded bytes for the compare, space marks one deeper
	logic [7:0]        cmp_q [MAX_TERM];
	logic [MAX_TERM:0] sp_q;
	logic [7:0]        held_raw_q;
	logic              held_valid_q;
	logic              held_match_q;
	logic [CW-1:0]     seen_q;
	logic [CW-1:0]     since_q;
	wwtm_pkg::res_t    ob_q [wwtm_pkg::RES_MAX];
	logic [1:0]        ob_cnt_q;

	logic [wwtm_pkg::TERM_BYTES-1:0][7:0] tbytes;
	logic [7:0]        tfold [wwtm_pkg::TERM_BYTES];
	logic [LEN_W-1:0]  len;
	logic              flag;
	logic [CW-1:0]     since_mid;
	logic [CW-1:0]     since_nx;
	logic [CW-1:0]     seen_nx;
	logic [7:0]        cmp_nx [MAX_TERM];
	logic [MAX_TERM:0] sp_nx;
	logic [LEN_W-1:0]  idx;
	logic [7:0]        tb;
	logic              win_ok;
	logic              boundary;
	logic              cur_match;
	logic [CMP_W-1:0]  len_x;
	logic [CMP_W-1:0]  seen_x;
	logic [CMP_W-1:0]  since_x;
	wwtm_pkg::res_t    held_res;
	wwtm_pkg::res_t    eot_res;
	logic [1:0]        nres;
	logic [1:0]        add;
	logic              out_pop;
	logic [1:0]        cnt_after;
	logic [2:0]        room_need;
	logic              take;
	wwtm_pkg::res_t    ob_nx [wwtm_pkg::RES_MAX];

	assign tbytes = cfg.term_word;
	assign len    = wwtm_pkg::eff_len(cfg.term_length, MAX_TERM);

	always_comb begin
		for (int k = 0; k < wwtm_pkg::TERM_BYTES; k++) begin
			tfold[k] = wwtm_pkg::fold_byte(tbytes[k], cfg.ignore_case);
		end
	end

	// counters and history as they stand after this byte
	assign flag      = held_valid_q && held_match_q && item.is_delim;
	assign since_mid = flag ? '0 : since_q;
	assign since_nx  = (since_mid < CW'(SAT)) ? since_mid + 1'b1 : since_mid;
	assign seen_nx   = (seen_q < CW'(SAT)) ? seen_q + 1'b1 : seen_q;
	assign sp_nx     = {sp_q[MAX_TERM-1:0], item.is_space};

	always_comb begin
		cmp_nx[0] = item.cmp_byte;
		for (int j = 1; j < MAX_TERM; j++) begin
			cmp_nx[j] = cmp_q[j-1];
		end
	end

	// newest byte lines up with the last term byte
	always_comb begin
		win_ok = 1'b1;
		idx    = '0;
		tb     = '0;
		for (int j = 0; j < MAX_TERM; j++) begin
			idx = len - LEN_W'(j) - LEN_W'(1);
			tb  = (idx < LEN_W'(wwtm_pkg::TERM_BYTES)) ? tfold[idx[wwtm_pkg::TB_W-1:0]] : '0;
			if ((LEN_W'(j) < len) && (cmp_nx[j] != tb)) begin
				win_ok = 1'b0;
			end
		end
	end

	assign len_x     = CMP_W'(len);
	assign seen_x    = CMP_W'(seen_nx);
	assign since_x   = CMP_W'(since_nx);
	assign boundary  = (seen_x == len_x) || (since_x == len_x) || sp_nx[SPW'(len)];
	assign cur_match = (len != '0) && (seen_x >= len_x) && (since_x >= len_x) &&
		win_ok && boundary;

	assign held_res = '{out_byte: held_raw_q, flag_after: flag, last_of_segment: 1'b0};
	assign eot_res  = '{out_byte: item.text_byte, flag_after: cur_match, last_of_segment: 1'b1};
	assign nres     = {1'b0, held_valid_q} + {1'b0, item.end_of_text};

	assign result_valid = (ob_cnt_q != '0);
	assign result       = ob_q[0];
	assign out_pop      = result_valid && result_ready;
	assign cnt_after    = ob_cnt_q - {1'b0, out_pop};
	assign room_need    = {1'b0, cnt_after} + {1'b0, nres};
	assign item_ready   = (room_need <= 3'(wwtm_pkg::RES_MAX));
	assign take         = item_valid && item_ready;
	assign add          = take ? nres : 2'd0;

	always_comb begin
		ob_nx[0] = out_pop ? ob_q[1] : ob_q[0];
		ob_nx[1] = ob_q[1];
		priority if (cnt_after == 2'd0) begin
			if (add != 2'd0) begin
				ob_nx[0] = held_valid_q ? held_res : eot_res;
			end
			if (add == 2'd2) begin
				ob_nx[1] = eot_res;
			end
		end else if (cnt_after == 2'd1) begin
			if (add != 2'd0) begin
				ob_nx[1] = held_valid_q ? held_res : eot_res;
			end
		end else begin
			ob_nx[1] = ob_q[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q     <= '0;
			held_valid_q <= 1'b0;
			held_match_q <= 1'b0;
			seen_q       <= '0;
			since_q      <= CW'(SAT);
		end else begin
			ob_cnt_q <= cnt_after + add;
			if (take) begin
				if (item.end_of_text) begin
					held_valid_q <= 1'b0;
					held_match_q <= 1'b0;
					seen_q       <= '0;
					since_q      <= CW'(SAT);
				end else begin
					held_valid_q <= 1'b1;
					held_match_q <= cur_match;
					seen_q       <= seen_nx;
					since_q      <= since_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		ob_q <= ob_nx;
		if (take) begin
			cmp_q      <= cmp_nx;
			sp_q       <= sp_nx;
			held_raw_q <= item.text_byte;
		end
	end

endmodule
`default_nettype wire
